// ===== hdl/mmn_pkg.sv =====
package mmn_pkg;

  // Default geometry and sample format
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RST  = 9'd256;

  // Input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  // Output pixel: quotient of (off * 256) / span has 9 bits, saturated to 8
  localparam int PIX_W     = 8;
  localparam int QUO_W     = PIX_W + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [PIX_W-1:0] PIX_SAT  = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_ZERO = '0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;  // write sample, update extremes and load count
    logic rd;    // issue store read at read count
    logic prep;  // capture offset and span, start divider
    logic step;  // one restoring-divider step
    logic emit;  // load output register, advance readout
  } mmn_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic readout;   // frame loaded, readout phase
    logic div_last;  // final divider step in progress
    logic out_free;  // output register can take a word this cycle
  } mmn_stat_t;

endpackage

// ===== hdl/mmn_if.sv =====
interface mmn_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, func, sample, input ready);
  modport sink   (input valid, func, sample, output ready);
endinterface

interface mmn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;

  modport source (output valid, pixel, last_pixel, input ready);
  modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface mmn_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mmn_ram.sv =====
module mmn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mmn_ctrl.sv =====
module mmn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  input  mmn_pkg::mmn_stat_t  stat,
  output logic                in_ready,
  output mmn_pkg::mmn_cmd_t   cmd
);
  import mmn_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  assign accept = in_valid && (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && stat.readout && (in_func == FUNC_REQ)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = accept && !stat.readout && (in_func == FUNC_LOAD);
        cmd.rd   = accept && stat.readout && (in_func == FUNC_REQ);
      end
      S_READ: begin
        cmd.prep = 1'b1;
      end
      S_DIV: begin
        cmd.step = 1'b1;
      end
      S_DONE: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/mmn_dp.sv =====
module mmn_dp #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input word payload
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [mmn_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [mmn_pkg::CFG_DATA_W-1:0]       cfg_data,
  // result word
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mmn_pkg::PIX_W-1:0]            out_pixel,
  output logic                                 out_last_pixel,
  // control
  input  mmn_pkg::mmn_cmd_t                    cmd,
  output mmn_pkg::mmn_stat_t                   stat
);
  import mmn_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SB     = SAMPLE_BITS;

  // config
  logic [CFG_DATA_W-1:0] width_r, width_nxt;
  logic [CFG_DATA_W-1:0] height_r, height_nxt;
  logic [CNT_W-1:0]      cw, ch, frame_size;

  // frame state
  logic                 readout_r, readout_nxt;
  logic [CNT_W-1:0]     load_cnt_r, load_cnt_nxt, load_cnt_inc;
  logic [CNT_W-1:0]     read_cnt_r, read_cnt_nxt, read_cnt_inc;
  logic signed [SB-1:0] max_r, max_nxt;
  logic signed [SB-1:0] min_r, min_nxt;

  // store
  logic [SB-1:0]        rd_data;
  logic signed [SB:0]   off, span;

  // divider
  logic [SB-1:0]        rem_r, rem_nxt;
  logic [SB-1:0]        span_r, span_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 zero_r, zero_nxt;
  logic [SB:0]          cur, diff;
  logic                 ge;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]     pixel_r, pixel_nxt;
  logic                 last_r, last_nxt;
  logic                 last_now;

  // clamp: 0 counts as 1, oversize counts as the maximum
  always_comb begin
    int wi, hi;
    wi = int'(width_r);
    hi = int'(height_r);
    if (wi == 0) wi = 1;
    if (wi > MAX_WIDTH) wi = MAX_WIDTH;
    if (hi == 0) hi = 1;
    if (hi > MAX_HEIGHT) hi = MAX_HEIGHT;
    cw = CNT_W'(wi);
    ch = CNT_W'(hi);
  end

  assign frame_size   = CNT_W'(cw * ch);
  assign load_cnt_inc = load_cnt_r + 1'b1;
  assign read_cnt_inc = read_cnt_r + 1'b1;
  assign last_now     = (read_cnt_inc >= load_cnt_r);

  mmn_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (load_cnt_r[ADDR_W-1:0]),
    .wdata (in_sample),
    .re    (cmd.rd),
    .raddr (read_cnt_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  assign off  = $signed({rd_data[SB-1], rd_data}) - $signed({min_r[SB-1], min_r});
  assign span = $signed({max_r[SB-1], max_r}) - $signed({min_r[SB-1], min_r});

  // restoring step: first step compares unshifted, later ones shift in a zero
  assign cur  = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign diff = cur - {1'b0, span_r};
  assign ge   = (cur >= {1'b0, span_r});

  assign stat.readout  = readout_r;
  assign stat.div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    readout_nxt   = readout_r;
    load_cnt_nxt  = load_cnt_r;
    read_cnt_nxt  = read_cnt_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    rem_nxt       = rem_r;
    span_nxt      = span_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    pixel_nxt     = pixel_r;
    last_nxt      = last_r;

    if (cfg_we) begin
      if (cfg_idx == CFG_IDX_WIDTH) begin
        width_nxt = cfg_data;
      end else if (cfg_idx == CFG_IDX_HEIGHT) begin
        height_nxt = cfg_data;
      end
    end

    if (cmd.load) begin
      load_cnt_nxt = load_cnt_inc;
      if (in_sample > max_r) max_nxt = in_sample;
      if (in_sample < min_r) min_nxt = in_sample;
      if (load_cnt_inc >= frame_size) begin
        readout_nxt  = 1'b1;
        read_cnt_nxt = '0;
      end
    end

    if (cmd.prep) begin
      zero_nxt = (span == '0) || off[SB];
      rem_nxt  = off[SB-1:0];
      span_nxt = span[SB-1:0];
      quo_nxt  = '0;
      step_nxt = '0;
    end

    if (cmd.step) begin
      rem_nxt  = ge ? diff[SB-1:0] : cur[SB-1:0];
      quo_nxt  = {quo_r[QUO_W-2:0], ge};
      step_nxt = step_r + 1'b1;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (zero_r) begin
        pixel_nxt = PIX_ZERO;
      end else if (quo_r[QUO_W-1]) begin
        pixel_nxt = PIX_SAT;
      end else begin
        pixel_nxt = quo_r[PIX_W-1:0];
      end
      last_nxt     = last_now;
      read_cnt_nxt = read_cnt_inc;
      if (last_now) begin
        readout_nxt  = 1'b0;
        load_cnt_nxt = '0;
        read_cnt_nxt = '0;
        max_nxt      = '0;
        min_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_SIZE_RST;
      height_r    <= CFG_SIZE_RST;
      readout_r   <= 1'b0;
      load_cnt_r  <= '0;
      read_cnt_r  <= '0;
      max_r       <= '0;
      min_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      readout_r   <= readout_nxt;
      load_cnt_r  <= load_cnt_nxt;
      read_cnt_r  <= read_cnt_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    span_r  <= span_nxt;
    quo_r   <= quo_nxt;
    zero_r  <= zero_nxt;
    pixel_r <= pixel_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = pixel_r;
  assign out_last_pixel = last_r;

endmodule

// ===== hdl/minmax_normalize_to_8bit.sv =====
// A pixel request runs a store read, offset/span capture, 9 restoring-divider steps
//   (one quotient bit per cycle) and an output register load.
// No new input word is taken until that output register load; loads and
//   ignored words leave the sequencer idle.
// Reset (rst_n, synchronous, active low): loading phase, extremes and counts zero,
//   both size registers 256. The frame store is not cleared.
module minmax_normalize_to_8bit #(
  parameter int MAX_WIDTH   = mmn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = mmn_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mmn_in_if.sink      in_ch,
  mmn_out_if.source   out_ch,
  mmn_cfg_if.sink     cfg_ch
);
  import mmn_pkg::*;

  // Control/status between the sequencer and the datapath.
  mmn_cmd_t  cmd;
  mmn_stat_t stat;
  logic      cfg_we;

  // Config writes are always taken; the user must write them only while idle, the block does not enforce it.
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  // Sequencer: accepts one input word when idle. A load in loading phase
  // writes the store in that same cycle; a request in readout phase starts
  // the read/divide sequence; anything else is dropped.
  mmn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // Datapath: config registers, frame store, running extremes, counters,
  // serial divider for floor((s - min) * 256 / (max - min)) and the output
  // register. The output register frees the input side: a new word can be
  // accepted while a finished pixel still waits for out_ch.ready.
  mmn_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_ch.sample),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_pixel      (out_ch.pixel),
    .out_last_pixel (out_ch.last_pixel),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== bench/minmax_normalize_to_8bit_tb.sv =====
`timescale 1ns / 100ps

module minmax_normalize_to_8bit_tb;
  import mmn_pkg::*;

  localparam int STORE_DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 16;   // keep some margin
  localparam int RAND_ITEMS   = 600;

  // One output word as the block should present it
  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } pix_word_t;

  // Directed stimulus row; typed rows carry their expected word inline
  typedef struct packed {
    logic               func;
    logic signed [23:0] sample;
    bit                 typed;
    logic [7:0]         pixel;
    logic               last;
  } stim_row_t;

  // Sample mixes for random frames
  typedef enum int {
    SMP_WIDE,
    SMP_NARROW,
    SMP_ZERO,
    SMP_POS,
    SMP_NEG,
    SMP_CORNER
  } smp_mix_t;

  logic clk = 1'b0;
  logic rst_n;

  mmn_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
  mmn_out_if out_ch ();
  mmn_cfg_if cfg_ch ();

  minmax_normalize_to_8bit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the normalizer: frame store, running extremes, counters,
  // phase and size registers. Updated on every accepted word.
  // ---------------------------------------------------------------------------
  logic signed [23:0] fm_store [0:STORE_DEPTH-1];
  longint             hi_val, lo_val;
  int                 n_loaded, n_read;
  bit                 in_readout;
  logic [8:0]         reg_w, reg_h;

  pix_word_t pending_pixels [$];   // words still owed by the block
  int        fail_count;
  int        rand_items;
  bit        in_quiet, out_quiet;  // no-gap / no-stall stretches

  function automatic int clamp_dim(input logic [8:0] v, input int maxv);
    if (v == 9'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Apply one accepted word to the shadow state; returns 1 when a word comes out.
  function automatic bit predict_pixel(input logic f, input logic signed [23:0] s,
                                       output pix_word_t w);
    int     frame;
    longint v, span, off, q;
    w = '0;
    if (!in_readout) begin
      // requests while loading are dropped without effect
      if (f != FUNC_LOAD) return 1'b0;
      frame = clamp_dim(reg_w, MAX_WIDTH_DEF) * clamp_dim(reg_h, MAX_HEIGHT_DEF);
      v = s;
      if (n_loaded < STORE_DEPTH) begin
        fm_store[n_loaded] = s;
        n_loaded++;
      end
      if (v > hi_val) hi_val = v;
      if (v < lo_val) lo_val = v;
      // size is re-read on every load, so a shrink mid-frame ends loading here
      if (n_loaded >= frame) begin
        in_readout = 1'b1;
        n_read = 0;
      end
      return 1'b0;
    end
    // loads during readout are ignored
    if (f != FUNC_REQ) return 1'b0;
    v = (n_read < STORE_DEPTH) ? longint'(fm_store[n_read]) : 0;
    // flat frame and the minimum itself both map to 0
    if (hi_val <= lo_val || v <= lo_val) begin
      q = 0;
    end else begin
      span = hi_val - lo_val;
      off  = v - lo_val;
      q    = (off * 256) / span;
      if (q > 255) q = 255;   // the maximum sample lands exactly on 256
    end
    n_read++;
    w.pixel = q[7:0];
    w.last  = (n_read >= n_loaded);
    if (w.last) begin
      in_readout = 1'b0;
      n_loaded   = 0;
      n_read     = 0;
      hi_val     = 0;
      lo_val     = 0;
    end
    return 1'b1;
  endfunction

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch @%0t: %s", $time, msg);
  endfunction

  function automatic logic signed [23:0] draw_sample(input smp_mix_t mix);
    int t;
    case (mix)
      SMP_WIDE:   t = $urandom;
      SMP_NARROW: t = int'($urandom_range(0, 200)) - 100;
      SMP_ZERO:   t = 0;
      SMP_POS:    t = int'($urandom_range(1, 8388607));
      SMP_NEG:    t = -int'($urandom_range(1, 8388608));
      default: begin
        case ($urandom_range(0, 4))
          0: t = -8388608;
          1: t = 8388607;
          2: t = -1;
          3: t = 1;
          default: t = 0;
        endcase
      end
    endcase
    return t[23:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. valid is left high after a handshake; the next call either
  // keeps it high (no gap) or drops it, never both in one step.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic f, input logic signed [23:0] s,
                           input bit typed, input pix_word_t typed_w);
    int        gap;
    pix_word_t w;
    if ($urandom_range(0, 31) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.sample <= s;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    if (predict_pixel(f, s, w)) pending_pixels.push_back(typed ? typed_w : w);
  endtask

  task automatic send_rand(input logic f, input smp_mix_t mix);
    send_word(f, draw_sample(mix), 1'b0, '0);
    rand_items++;
  endtask

  // Stop sending and let the block finish whatever it holds.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both size registers; only called with the block idle.
  task automatic set_frame_size(input logic [8:0] w, input logic [8:0] h);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_IDX_WIDTH;
    cfg_ch.data  <= w;
    do @(posedge clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
    reg_w = w;
    cfg_ch.index <= CFG_IDX_HEIGHT;
    cfg_ch.data  <= h;
    do @(posedge clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
    reg_h = h;
    cfg_ch.valid <= 1'b0;
  endtask

  // One well-formed frame with random content and a sprinkle of stray words.
  // With shrink set, a few samples go in under the given size and then the
  // size is cut down mid-frame.
  task automatic run_frame(input logic [8:0] w, input logic [8:0] h, input bit shrink);
    smp_mix_t mix;
    mix = smp_mix_t'($urandom_range(0, 5));
    settle();
    set_frame_size(w, h);
    if (shrink) begin
      repeat ($urandom_range(1, 4)) send_rand(FUNC_LOAD, mix);
      settle();
      set_frame_size(9'($urandom_range(0, 3)), 9'($urandom_range(1, 2)));
    end
    while (!in_readout) send_rand(($urandom_range(0, 9) == 0) ? FUNC_REQ : FUNC_LOAD, mix);
    while (in_readout) send_rand(($urandom_range(0, 9) == 0) ? FUNC_LOAD : FUNC_REQ, mix);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows, all on a 2 x 2 frame.
  //   frame 1: full-scale extremes; min gives 0, max saturates, 0 sits at 128
  //   frame 2: all zero, so max equals min and every pixel is 0
  //   frame 3: mixed values, checked against the shadow model
  // Also: a request before any load, and a load in the middle of readout.
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [0:25] = '{
    '{FUNC_REQ,  24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, -24'sd8388608, 1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd8388607,  1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd123,      1'b0, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd255, 1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd128, 1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd128, 1'b1},
    '{FUNC_LOAD, 24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b1, 8'd0,   1'b1},
    '{FUNC_LOAD, 24'sd1000,     1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, -24'sd3,       1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, 24'sd77,       1'b0, 8'd0,   1'b0},
    '{FUNC_LOAD, -24'sd500000,  1'b0, 8'd0,   1'b0},
    '{FUNC_REQ,  -24'sd1,       1'b0, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b0, 8'd0,   1'b0},
    '{FUNC_REQ,  24'sd0,        1'b0, 8'd0,   1'b0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_LOAD;
    in_ch.sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_IDX_WIDTH;
    cfg_ch.data  <= '0;
    hi_val     = 0;
    lo_val     = 0;
    n_loaded   = 0;
    n_read     = 0;
    in_readout = 1'b0;
    reg_w      = CFG_SIZE_RST;
    reg_h      = CFG_SIZE_RST;
    fail_count = 0;
    rand_items = 0;
    in_quiet   = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_frame_size(9'd2, 9'd2);
    for (int i = 0; i < 26; i++) begin
      send_word(dir_rows[i].func, dir_rows[i].sample, dir_rows[i].typed,
                '{pixel: dir_rows[i].pixel, last: dir_rows[i].last});
    end

    // size extremes: a full 256 x 1 frame through the oversize and zero
    // clamps, then 256 and oversize heights cut short mid-frame
    run_frame(9'd511, 9'd0, 1'b0);
    run_frame(9'd256, 9'd256, 1'b1);
    run_frame(9'd0, 9'd511, 1'b1);
    run_frame(9'd1, 9'd1, 1'b0);
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 7) == 0)
        run_frame(9'($urandom_range(64, 511)), 9'($urandom_range(64, 511)), 1'b1);
      else
        run_frame(9'($urandom_range(1, 8)), 9'($urandom_range(1, 4)), 1'b0);
    end

    settle();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, every accepted word checked in order
  // ---------------------------------------------------------------------------
  initial begin
    int        stall;
    pix_word_t exp_w;
    out_ch.ready <= 1'b0;
    out_quiet = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      if (pending_pixels.size() == 0) begin
        note_fail($sformatf("unexpected word pixel=%0d last=%0b",
                            out_ch.pixel, out_ch.last_pixel));
      end else begin
        exp_w = pending_pixels.pop_front();
        if (out_ch.pixel !== exp_w.pixel)
          note_fail($sformatf("pixel exp %0d got %0d", exp_w.pixel, out_ch.pixel));
        if (out_ch.last_pixel !== exp_w.last)
          note_fail($sformatf("last_pixel exp %0b got %0b", exp_w.last, out_ch.last_pixel));
      end
    end
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
